// ----- sv/segment_triangle_intersect_unit_defines.svh -----
// Assertion macros shared by the segment/triangle intersect RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef SEGMENT_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH
`define SEGMENT_TRIANGLE_INTERSECT_UNIT_DEFINES_SVH

// same-cycle implication
`define STI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sti_pkg.sv -----
// Shared types and axis helpers for the segment/triangle intersect pipeline.
// No dependencies.
`default_nettype none

package sti_pkg;

  localparam int unsigned AXES = 3;

  typedef struct packed {
    logic adv;
    logic vld;
  } stage_ctl_t;

  function automatic int unsigned axis_next(input int unsigned k);
    return (k == AXES - 1) ? 0 : k + 1;
  endfunction

  function automatic int unsigned axis_prev(input int unsigned k);
    return (k == 0) ? AXES - 1 : k - 1;
  endfunction

endpackage

`default_nettype wire

// ----- sv/segment_triangle_intersect_unit.sv -----
// Segment/triangle hit test, six register stages (diff, cross, triple, sum, dot, range).
// The result leaves the range stage; one word per cycle is sustained while no stall holds the pipe.
// Throughput is set by the single pipeline stall: every stage holds while out_stall blocks
// a valid result. Synchronous active-low reset clears all stage valid bits.
// Uses sti_pkg, sti_front, sti_triple and sti_resolve.
`default_nettype none

module segment_triangle_intersect_unit #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0]      in_seg_start,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0]      in_seg_end,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0]      in_corner_a,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0]      in_corner_b,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0]      in_corner_c,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     out_hit
);

  localparam int unsigned PD  = COORD_BITS + 1;
  localparam int unsigned XW  = 2 * PD + 1;
  localparam int unsigned DDW = 2 * PD + 2;
  localparam int unsigned TW  = 3 * PD + 3;
  localparam int unsigned SW  = TW + 2;
  localparam int unsigned MW  = TW + PD + 2;

  logic                  adv;
  sti_pkg::stage_ctl_t   front_ctl;
  sti_pkg::stage_ctl_t   triple_ctl;
  sti_pkg::stage_ctl_t   resolve_ctl;

  logic                  f_vld;
  logic signed [PD-1:0]  f_pq  [sti_pkg::AXES];
  logic signed [PD-1:0]  f_pa  [sti_pkg::AXES];
  logic signed [PD-1:0]  f_pb  [sti_pkg::AXES];
  logic signed [PD-1:0]  f_pc  [sti_pkg::AXES];
  logic signed [XW-1:0]  f_xcb [sti_pkg::AXES];
  logic signed [XW-1:0]  f_xac [sti_pkg::AXES];
  logic signed [XW-1:0]  f_xba [sti_pkg::AXES];
  logic signed [DDW-1:0] f_dd;

  logic                  t_vld;
  logic signed [PD-1:0]  t_pq [sti_pkg::AXES];
  logic signed [DDW-1:0] t_dd;
  logic signed [MW-1:0]  t_m  [sti_pkg::AXES];
  logic signed [SW-1:0]  t_s;
  logic                  t_neg;

  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  assign front_ctl   = '{adv: adv, vld: in_valid};
  assign triple_ctl  = '{adv: adv, vld: f_vld};
  assign resolve_ctl = '{adv: adv, vld: t_vld};

  sti_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (front_ctl),
    .seg_start (in_seg_start),
    .seg_end   (in_seg_end),
    .corner_a  (in_corner_a),
    .corner_b  (in_corner_b),
    .corner_c  (in_corner_c),
    .vld_o     (f_vld),
    .pq_o      (f_pq),
    .pa_o      (f_pa),
    .pb_o      (f_pb),
    .pc_o      (f_pc),
    .xcb_o     (f_xcb),
    .xac_o     (f_xac),
    .xba_o     (f_xba),
    .dd_o      (f_dd)
  );

  sti_triple #(
    .COORD_BITS (COORD_BITS)
  ) u_triple (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (triple_ctl),
    .pq_i  (f_pq),
    .pa_i  (f_pa),
    .pb_i  (f_pb),
    .pc_i  (f_pc),
    .xcb_i (f_xcb),
    .xac_i (f_xac),
    .xba_i (f_xba),
    .dd_i  (f_dd),
    .vld_o (t_vld),
    .pq_o  (t_pq),
    .dd_o  (t_dd),
    .m_o   (t_m),
    .s_o   (t_s),
    .neg_o (t_neg)
  );

  sti_resolve #(
    .COORD_BITS (COORD_BITS)
  ) u_resolve (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (resolve_ctl),
    .pq_i  (t_pq),
    .dd_i  (t_dd),
    .m_i   (t_m),
    .s_i   (t_s),
    .neg_i (t_neg),
    .vld_o (out_valid),
    .hit_o (out_hit)
  );

endmodule

`default_nettype wire

// ----- sv/sti_front.sv -----
// Stages 1-2: edge vectors from the segment start, then cross products and pq.pq.
// Uses sti_pkg and the assertion macros header.
`default_nettype none
`include "segment_triangle_intersect_unit_defines.svh"

module sti_front #(
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned PW  = sti_pkg::AXES * COORD_BITS,
  localparam int unsigned PD  = COORD_BITS + 1,
  localparam int unsigned XW  = 2 * PD + 1,
  localparam int unsigned DDW = 2 * PD + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sti_pkg::stage_ctl_t   ctl,
  input  logic [PW-1:0]         seg_start,
  input  logic [PW-1:0]         seg_end,
  input  logic [PW-1:0]         corner_a,
  input  logic [PW-1:0]         corner_b,
  input  logic [PW-1:0]         corner_c,
  output logic                  vld_o,
  output logic signed [PD-1:0]  pq_o  [sti_pkg::AXES],
  output logic signed [PD-1:0]  pa_o  [sti_pkg::AXES],
  output logic signed [PD-1:0]  pb_o  [sti_pkg::AXES],
  output logic signed [PD-1:0]  pc_o  [sti_pkg::AXES],
  output logic signed [XW-1:0]  xcb_o [sti_pkg::AXES],
  output logic signed [XW-1:0]  xac_o [sti_pkg::AXES],
  output logic signed [XW-1:0]  xba_o [sti_pkg::AXES],
  output logic signed [DDW-1:0] dd_o
);

  logic                  v1_r;
  logic                  v2_r;
  logic signed [PD-1:0]  pq1_nxt [sti_pkg::AXES];
  logic signed [PD-1:0]  pa1_nxt [sti_pkg::AXES];
  logic signed [PD-1:0]  pb1_nxt [sti_pkg::AXES];
  logic signed [PD-1:0]  pc1_nxt [sti_pkg::AXES];
  logic signed [PD-1:0]  pq1_r   [sti_pkg::AXES];
  logic signed [PD-1:0]  pa1_r   [sti_pkg::AXES];
  logic signed [PD-1:0]  pb1_r   [sti_pkg::AXES];
  logic signed [PD-1:0]  pc1_r   [sti_pkg::AXES];
  logic signed [XW-1:0]  xcb_nxt [sti_pkg::AXES];
  logic signed [XW-1:0]  xac_nxt [sti_pkg::AXES];
  logic signed [XW-1:0]  xba_nxt [sti_pkg::AXES];
  logic signed [XW-1:0]  xcb_r   [sti_pkg::AXES];
  logic signed [XW-1:0]  xac_r   [sti_pkg::AXES];
  logic signed [XW-1:0]  xba_r   [sti_pkg::AXES];
  logic signed [PD-1:0]  pq2_r   [sti_pkg::AXES];
  logic signed [PD-1:0]  pa2_r   [sti_pkg::AXES];
  logic signed [PD-1:0]  pb2_r   [sti_pkg::AXES];
  logic signed [PD-1:0]  pc2_r   [sti_pkg::AXES];
  logic signed [DDW-1:0] dd_nxt;
  logic signed [DDW-1:0] dd_r;

  function automatic logic signed [PD-1:0] axis_diff(
    input logic [PW-1:0] to_pt,
    input logic [PW-1:0] from_pt,
    input int unsigned   k
  );
    logic signed [COORD_BITS-1:0] t;
    logic signed [COORD_BITS-1:0] f;
    t = to_pt[k*COORD_BITS +: COORD_BITS];
    f = from_pt[k*COORD_BITS +: COORD_BITS];
    return PD'(t) - PD'(f);
  endfunction

  function automatic logic signed [XW-1:0] cross_axis(
    input logic signed [PD-1:0] y_n,
    input logic signed [PD-1:0] y_p,
    input logic signed [PD-1:0] z_n,
    input logic signed [PD-1:0] z_p
  );
    return XW'(y_n) * XW'(z_p) - XW'(y_p) * XW'(z_n);
  endfunction

  for (genvar k = 0; k < sti_pkg::AXES; k++) begin : g_axis
    localparam int unsigned KN = sti_pkg::axis_next(k);
    localparam int unsigned KP = sti_pkg::axis_prev(k);

    assign pq1_nxt[k] = axis_diff(seg_end,  seg_start, k);
    assign pa1_nxt[k] = axis_diff(corner_a, seg_start, k);
    assign pb1_nxt[k] = axis_diff(corner_b, seg_start, k);
    assign pc1_nxt[k] = axis_diff(corner_c, seg_start, k);

    assign xcb_nxt[k] = cross_axis(pc1_r[KN], pc1_r[KP], pb1_r[KN], pb1_r[KP]);
    assign xac_nxt[k] = cross_axis(pa1_r[KN], pa1_r[KP], pc1_r[KN], pc1_r[KP]);
    assign xba_nxt[k] = cross_axis(pb1_r[KN], pb1_r[KP], pa1_r[KN], pa1_r[KP]);
  end

  assign dd_nxt = DDW'(pq1_r[0]) * DDW'(pq1_r[0])
                + DDW'(pq1_r[1]) * DDW'(pq1_r[1])
                + DDW'(pq1_r[2]) * DDW'(pq1_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (ctl.adv) begin
      v1_r <= ctl.vld;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      pq1_r <= pq1_nxt;
      pa1_r <= pa1_nxt;
      pb1_r <= pb1_nxt;
      pc1_r <= pc1_nxt;
      xcb_r <= xcb_nxt;
      xac_r <= xac_nxt;
      xba_r <= xba_nxt;
      dd_r  <= dd_nxt;
      pq2_r <= pq1_r;
      pa2_r <= pa1_r;
      pb2_r <= pb1_r;
      pc2_r <= pc1_r;
    end
  end

  assign vld_o = v2_r;
  assign pq_o  = pq2_r;
  assign pa_o  = pa2_r;
  assign pb_o  = pb2_r;
  assign pc_o  = pc2_r;
  assign xcb_o = xcb_r;
  assign xac_o = xac_r;
  assign xba_o = xba_r;
  assign dd_o  = dd_r;

  `STI_ASSERT_NEXT(a_front_reach, (ctl.adv && ctl.vld ##1 ctl.adv), v2_r, "front lost a word")

endmodule

`default_nettype wire

// ----- sv/sti_triple.sv -----
// Stages 3-4: triple products u, v, w, then weighted sum m, sum s and sign flag.
// Uses sti_pkg and the assertion macros header.
`default_nettype none
`include "segment_triangle_intersect_unit_defines.svh"

module sti_triple #(
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned PD  = COORD_BITS + 1,
  localparam int unsigned XW  = 2 * PD + 1,
  localparam int unsigned DDW = 2 * PD + 2,
  localparam int unsigned TW  = 3 * PD + 3,
  localparam int unsigned SW  = TW + 2,
  localparam int unsigned MW  = TW + PD + 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sti_pkg::stage_ctl_t   ctl,
  input  logic signed [PD-1:0]  pq_i  [sti_pkg::AXES],
  input  logic signed [PD-1:0]  pa_i  [sti_pkg::AXES],
  input  logic signed [PD-1:0]  pb_i  [sti_pkg::AXES],
  input  logic signed [PD-1:0]  pc_i  [sti_pkg::AXES],
  input  logic signed [XW-1:0]  xcb_i [sti_pkg::AXES],
  input  logic signed [XW-1:0]  xac_i [sti_pkg::AXES],
  input  logic signed [XW-1:0]  xba_i [sti_pkg::AXES],
  input  logic signed [DDW-1:0] dd_i,
  output logic                  vld_o,
  output logic signed [PD-1:0]  pq_o [sti_pkg::AXES],
  output logic signed [DDW-1:0] dd_o,
  output logic signed [MW-1:0]  m_o  [sti_pkg::AXES],
  output logic signed [SW-1:0]  s_o,
  output logic                  neg_o
);

  logic                  v3_r;
  logic                  v4_r;
  logic signed [TW-1:0]  u_nxt;
  logic signed [TW-1:0]  v_nxt;
  logic signed [TW-1:0]  w_nxt;
  logic signed [TW-1:0]  u_r;
  logic signed [TW-1:0]  v_r;
  logic signed [TW-1:0]  w_r;
  logic signed [PD-1:0]  pq3_r [sti_pkg::AXES];
  logic signed [PD-1:0]  pa3_r [sti_pkg::AXES];
  logic signed [PD-1:0]  pb3_r [sti_pkg::AXES];
  logic signed [PD-1:0]  pc3_r [sti_pkg::AXES];
  logic signed [DDW-1:0] dd3_r;
  logic signed [MW-1:0]  m_nxt [sti_pkg::AXES];
  logic signed [MW-1:0]  m4_r  [sti_pkg::AXES];
  logic signed [SW-1:0]  s_nxt;
  logic signed [SW-1:0]  s4_r;
  logic                  neg_nxt;
  logic                  neg4_r;
  logic signed [PD-1:0]  pq4_r [sti_pkg::AXES];
  logic signed [DDW-1:0] dd4_r;

  function automatic logic signed [TW-1:0] dot_px(
    input logic signed [PD-1:0] p [sti_pkg::AXES],
    input logic signed [XW-1:0] x [sti_pkg::AXES]
  );
    return TW'(p[0]) * TW'(x[0]) + TW'(p[1]) * TW'(x[1]) + TW'(p[2]) * TW'(x[2]);
  endfunction

  assign u_nxt = dot_px(pq_i, xcb_i);
  assign v_nxt = dot_px(pq_i, xac_i);
  assign w_nxt = dot_px(pq_i, xba_i);

  for (genvar k = 0; k < sti_pkg::AXES; k++) begin : g_axis
    assign m_nxt[k] = MW'(u_r) * MW'(pa3_r[k])
                    + MW'(v_r) * MW'(pb3_r[k])
                    + MW'(w_r) * MW'(pc3_r[k]);
  end

  assign s_nxt   = SW'(u_r) + SW'(v_r) + SW'(w_r);
  assign neg_nxt = u_r[TW-1] | v_r[TW-1] | w_r[TW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (ctl.adv) begin
      v3_r <= ctl.vld;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      u_r    <= u_nxt;
      v_r    <= v_nxt;
      w_r    <= w_nxt;
      pq3_r  <= pq_i;
      pa3_r  <= pa_i;
      pb3_r  <= pb_i;
      pc3_r  <= pc_i;
      dd3_r  <= dd_i;
      m4_r   <= m_nxt;
      s4_r   <= s_nxt;
      neg4_r <= neg_nxt;
      pq4_r  <= pq3_r;
      dd4_r  <= dd3_r;
    end
  end

  assign vld_o = v4_r;
  assign pq_o  = pq4_r;
  assign dd_o  = dd4_r;
  assign m_o   = m4_r;
  assign s_o   = s4_r;
  assign neg_o = neg4_r;

  `STI_ASSERT_NEXT(a_triple_hold, !ctl.adv, $stable(v3_r) && $stable(v4_r), "triple valid moved")

endmodule

`default_nettype wire

// ----- sv/sti_resolve.sv -----
// Stages 5-6: N = m.pq and split s*pq.pq, then the range test into the output register.
// Uses sti_pkg and the assertion macros header.
`default_nettype none
`include "segment_triangle_intersect_unit_defines.svh"

module sti_resolve #(
  parameter int unsigned COORD_BITS = 12,
  localparam int unsigned PD  = COORD_BITS + 1,
  localparam int unsigned DDW = 2 * PD + 2,
  localparam int unsigned TW  = 3 * PD + 3,
  localparam int unsigned SW  = TW + 2,
  localparam int unsigned MW  = TW + PD + 2,
  localparam int unsigned NW  = MW + PD + 2,
  localparam int unsigned SLO = SW / 2,
  localparam int unsigned PLW = SLO + 1 + DDW,
  localparam int unsigned PHW = SW - SLO + DDW,
  localparam int unsigned CW  = SW + DDW + 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sti_pkg::stage_ctl_t   ctl,
  input  logic signed [PD-1:0]  pq_i [sti_pkg::AXES],
  input  logic signed [DDW-1:0] dd_i,
  input  logic signed [MW-1:0]  m_i  [sti_pkg::AXES],
  input  logic signed [SW-1:0]  s_i,
  input  logic                  neg_i,
  output logic                  vld_o,
  output logic                  hit_o
);

  logic                  v5_r;
  logic                  vld_r;
  logic signed [NW-1:0]  n_nxt;
  logic signed [NW-1:0]  n5_r;
  logic signed [PLW-1:0] lo_nxt;
  logic signed [PLW-1:0] lo5_r;
  logic signed [PHW-1:0] hi_nxt;
  logic signed [PHW-1:0] hi5_r;
  logic                  skip_nxt;
  logic                  skip5_r;
  logic signed [CW-1:0]  lim;
  logic signed [CW-1:0]  gap;
  logic                  hit_nxt;
  logic                  hit_r;

  assign n_nxt = NW'(m_i[0]) * NW'(pq_i[0])
               + NW'(m_i[1]) * NW'(pq_i[1])
               + NW'(m_i[2]) * NW'(pq_i[2]);

  assign lo_nxt   = PLW'(signed'({1'b0, s_i[SLO-1:0]})) * PLW'(dd_i);
  assign hi_nxt   = PHW'(signed'(s_i[SW-1:SLO])) * PHW'(dd_i);
  assign skip_nxt = neg_i | (s_i == '0);

  assign lim     = (CW'(hi5_r) <<< SLO) + CW'(lo5_r);
  assign gap     = lim - CW'(n5_r);
  assign hit_nxt = v5_r & ~skip5_r & ~n5_r[NW-1] & ~gap[CW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r  <= 1'b0;
      vld_r <= 1'b0;
      hit_r <= 1'b0;
    end else if (ctl.adv) begin
      v5_r  <= ctl.vld;
      vld_r <= v5_r;
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      n5_r    <= n_nxt;
      lo5_r   <= lo_nxt;
      hi5_r   <= hi_nxt;
      skip5_r <= skip_nxt;
    end
  end

  assign vld_o = vld_r;
  assign hit_o = hit_r;

  `STI_ASSERT_NOW(a_hit_needs_word, hit_r, vld_r, "hit without a valid word")
  `STI_ASSERT_NEXT(a_resolve_reach, (ctl.adv && ctl.vld ##1 ctl.adv), vld_r, "resolve lost a word")

endmodule

`default_nettype wire

// ----- bench/segment_triangle_intersect_checker.sv -----
// Hit checker for segment_triangle_intersect_unit: watches both channels, works out
// the expected hit bit of every accepted input word and compares it with the result words.
// Depends on sti_pkg for the axis count.
module segment_triangle_intersect_checker #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0] in_seg_start,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0] in_seg_end,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0] in_corner_a,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0] in_corner_b,
  input  logic [sti_pkg::AXES*COORD_BITS-1:0] in_corner_c,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_hit,
  output int                                  fail_count,
  output int                                  pending_words
);

  localparam int unsigned WORD_W = sti_pkg::AXES * COORD_BITS;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic signed [127:0] wide_t;

  bit hit_q[$];
  int n_fail = 0;
  bit want_hit;

  function automatic wide_t axis_value(input word_t pt, input int unsigned k);
    logic signed [COORD_BITS-1:0] raw;
    raw = pt[k*COORD_BITS +: COORD_BITS];
    return raw;
  endfunction

  function automatic wide_t triple_product(input wide_t d0, d1, d2, y0, y1, y2,
                                           z0, z1, z2);
    return d0 * (y1 * z2 - y2 * z1) + d1 * (y2 * z0 - y0 * z2)
         + d2 * (y0 * z1 - y1 * z0);
  endfunction

  function automatic bit segment_crosses(input word_t p, q, a, b, c);
    wide_t pq[3], pa[3], pb[3], pc[3];
    wide_t u, v, w, s, n, span;
    int unsigned k;
    for (k = 0; k < sti_pkg::AXES; k++) begin
      pq[k] = axis_value(q, k) - axis_value(p, k);
      pa[k] = axis_value(a, k) - axis_value(p, k);
      pb[k] = axis_value(b, k) - axis_value(p, k);
      pc[k] = axis_value(c, k) - axis_value(p, k);
    end
    u = triple_product(pq[0], pq[1], pq[2], pc[0], pc[1], pc[2], pb[0], pb[1], pb[2]);
    v = triple_product(pq[0], pq[1], pq[2], pa[0], pa[1], pa[2], pc[0], pc[1], pc[2]);
    w = triple_product(pq[0], pq[1], pq[2], pb[0], pb[1], pb[2], pa[0], pa[1], pa[2]);
    if (u < 0 || v < 0 || w < 0) return 1'b0;
    s = u + v + w;
    if (s == 0) return 1'b0;
    n    = 0;
    span = 0;
    for (k = 0; k < sti_pkg::AXES; k++) begin
      n    = n + (u * pa[k] + v * pb[k] + w * pc[k]) * pq[k];
      span = span + pq[k] * pq[k];
    end
    return (n >= 0) && (n <= s * span);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          n_fail++;
          $display("%0t unexpected result word: expected none, actual hit=%0b",
                   $time, out_hit);
        end else begin
          want_hit = hit_q.pop_front();
          if (out_hit !== want_hit) begin
            n_fail++;
            $display("%0t hit mismatch: expected %0b, actual %0b",
                     $time, want_hit, out_hit);
          end
        end
      end
      if (in_valid && !in_stall)
        hit_q.push_back(segment_crosses(in_seg_start, in_seg_end, in_corner_a,
                                        in_corner_b, in_corner_c));
    end
    fail_count    <= n_fail;
    pending_words <= hit_q.size();
  end

endmodule

// ----- bench/tb_segment_triangle_intersect_unit.sv -----
// Top of the segment/triangle intersect bench: clock, reset, directed and random input
// words under several idle and stall mixes, watchdog and verdict.
// Depends on sti_pkg, segment_triangle_intersect_unit and segment_triangle_intersect_checker.
module tb_segment_triangle_intersect_unit;

  localparam int unsigned COORD_BITS      = 12;
  localparam int unsigned WORD_W          = sti_pkg::AXES * COORD_BITS;
  localparam int          CMAX            = (1 << (COORD_BITS - 1)) - 1;
  localparam int          CMIN            = -(1 << (COORD_BITS - 1));
  localparam int          ITEMS_PER_PHASE = 333;
  localparam int          PHASES          = 4;
  localparam int          TAIL_CYCLES     = 12;
  localparam int          WATCHDOG_LIMIT  = 2000;

  typedef logic [WORD_W-1:0] word_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  word_t in_seg_start;
  word_t in_seg_end;
  word_t in_corner_a;
  word_t in_corner_b;
  word_t in_corner_c;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  out_hit;
  int    fail_count;
  int    pending_words;
  int    send_idle_pct;
  int    stall_pct;
  int    idle_cycles;

  segment_triangle_intersect_unit #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_seg_start(in_seg_start),
    .in_seg_end  (in_seg_end),
    .in_corner_a (in_corner_a),
    .in_corner_b (in_corner_b),
    .in_corner_c (in_corner_c),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_hit     (out_hit)
  );

  segment_triangle_intersect_checker #(
    .COORD_BITS(COORD_BITS)
  ) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_seg_start (in_seg_start),
    .in_seg_end   (in_seg_end),
    .in_corner_a  (in_corner_a),
    .in_corner_b  (in_corner_b),
    .in_corner_c  (in_corner_c),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hit      (out_hit),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  function automatic word_t pt(input int x, input int y, input int z);
    return {z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
  endfunction

  function automatic int spread(input int m);
    return int'($urandom_range(2 * m)) - m;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(7))
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      3: return -1;
      default: return int'($urandom_range(CMAX - CMIN)) + CMIN;
    endcase
  endfunction

  function automatic word_t rand_point();
    return pt(rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic send_word(input word_t p, q, a, b, c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_seg_start <= p;
    in_seg_end   <= q;
    in_corner_a  <= a;
    in_corner_b  <= b;
    in_corner_c  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // send with both windings of the triangle
  task automatic send_both(input word_t p, q, a, b, c);
    send_word(p, q, a, b, c);
    send_word(p, q, a, c, b);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    word_t a, b, c;
    a = pt(CMIN, CMIN, 0);
    b = pt(CMAX, CMIN, 0);
    c = pt(0, CMAX, 0);
    send_word('0, '0, '0, '0, '0);
    send_word('1, '1, '1, '1, '1);
    send_word(pt(CMAX, CMAX, CMAX), pt(CMAX, CMAX, CMAX), pt(CMAX, CMAX, CMAX),
              pt(CMAX, CMAX, CMAX), pt(CMAX, CMAX, CMAX));
    send_word(pt(CMIN, CMIN, CMIN), pt(CMIN, CMIN, CMIN), pt(CMIN, CMIN, CMIN),
              pt(CMIN, CMIN, CMIN), pt(CMIN, CMIN, CMIN));
    send_both(pt(0, 0, CMIN), pt(0, 0, CMAX), a, b, c);
    send_both(pt(CMIN, CMIN, CMIN), pt(CMAX, CMAX, CMAX), a, b, c);
    send_both(pt(0, 0, 0), pt(0, 0, 100), a, b, c);
    send_both(pt(0, 0, -100), pt(0, 0, 0), a, b, c);
    send_both(pt(5, 5, 1), pt(5, 5, 100), a, b, c);
    send_both(pt(5, 5, -100), pt(5, 5, -1), a, b, c);
    send_both(pt(7, 7, 9), pt(7, 7, 9), a, b, c);
    send_both(pt(CMIN + 1, 0, 0), pt(CMAX, 0, 0), a, b, c);
    send_both(pt(CMIN, CMIN, -5), pt(CMIN, CMIN, 5), a, b, c);
    repeat (3) send_word(rand_point(), rand_point(), rand_point(), rand_point(),
                         rand_point());
  endtask

  // mostly a triangle around a center and a segment through a chosen target point
  task automatic make_item(output word_t p, q, a, b, c);
    int ctr[3], oa[3], rr[3], dir[3], tgt[3];
    int t_in, t_out, aim, kind, k;
    kind = $urandom_range(99);
    if (kind < 15) begin
      p = rand_point();
      q = rand_point();
      a = rand_point();
      b = rand_point();
      c = rand_point();
      return;
    end
    t_in  = ($urandom_range(7) == 0) ? 0 : $urandom_range(3, 1);
    t_out = ($urandom_range(7) == 0) ? 0 : $urandom_range(3, 1);
    aim   = $urandom_range(9);
    for (k = 0; k < 3; k++) begin
      ctr[k] = spread(300);
      oa[k]  = spread(300);
      rr[k]  = spread(150);
      dir[k] = spread(150);
      if (aim < 6) tgt[k] = ctr[k];
      else if (aim < 7) tgt[k] = ctr[k] + rr[k];
      else if (aim < 8) tgt[k] = ctr[k] + oa[k];
      else tgt[k] = ctr[k] + 2 * oa[k];
    end
    p = pt(tgt[0] - t_in * dir[0], tgt[1] - t_in * dir[1], tgt[2] - t_in * dir[2]);
    q = pt(tgt[0] + t_out * dir[0], tgt[1] + t_out * dir[1], tgt[2] + t_out * dir[2]);
    a = pt(ctr[0] + oa[0], ctr[1] + oa[1], ctr[2] + oa[2]);
    b = pt(ctr[0] + 2 * rr[0] - oa[0], ctr[1] + 2 * rr[1] - oa[1],
           ctr[2] + 2 * rr[2] - oa[2]);
    c = pt(ctr[0] - 2 * rr[0], ctr[1] - 2 * rr[1], ctr[2] - 2 * rr[2]);
    if (kind >= 85) begin
      case ($urandom_range(5))
        0: p = rand_point();
        1: q = rand_point();
        2: a = rand_point();
        3: b = rand_point();
        4: c = rand_point();
        default: q = p;
      endcase
    end
  endtask

  initial begin
    word_t p, q, a, b, c;
    int ph, i;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_seg_start  = '0;
    in_seg_end    = '0;
    in_corner_a   = '0;
    in_corner_b   = '0;
    in_corner_c   = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct    <= 0;
        end
        1: begin
          send_idle_pct = 67;
          stall_pct    <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct    <= 67;
        end
        default: begin
          send_idle_pct = 37;
          stall_pct    <= 37;
        end
      endcase
      if (ph == 0) run_directed();
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(149) == 0) drain_results();
        make_item(p, q, a, b, c);
        send_word(p, q, a, b, c);
      end
      drain_results();
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/sti_pkg.sv
sv/sti_front.sv
sv/sti_triple.sv
sv/sti_resolve.sv
sv/segment_triangle_intersect_unit.sv
bench/segment_triangle_intersect_checker.sv
bench/tb_segment_triangle_intersect_unit.sv
